// File: src/ufe_pkg.sv
// ufe_pkg: shared widths, codes and controller/datapath interface types
// for the disjoint-set engine. No dependencies.
`default_nettype none
package ufe_pkg;

    localparam int KIND_W           = 2;
    localparam int IDX_W            = 10;
    localparam int CNT_W            = 11;
    localparam int SIZE_W           = 11;
    localparam int DATA_W           = 32;
    localparam int PADDR_W          = 3;
    localparam int DEF_MAX_ELEMENTS = 1024;

    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNION = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic REG_ELEMENT_COUNT = 1'b0;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic load_b;
        logic rd_data_sel;
        logic hop;
        logic save_ra;
        logic save_rb;
        logic set_err;
        logic sz_sel_rb;
        logic latch_sza;
        logic link;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              idx_err;
        logic              is_root;
        logic              same_root;
        logic              clr_last;
    } t_status;

endpackage
`default_nettype wire

// File: src/ufe_ctrl.sv
// ufe_ctrl: sequencing state machine of the disjoint-set engine.
// Depends on ufe_pkg for the command and status types.
`default_nettype none
module ufe_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  ufe_pkg::t_status i_status,
    output ufe_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    import ufe_pkg::*;

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_CLR  = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_HOP  = 4'd6;
    localparam logic [3:0] S_SZA  = 4'd7;
    localparam logic [3:0] S_SZB  = 4'd8;
    localparam logic [3:0] S_LINK = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_second;
    logic       n_second;

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        o_cmd    = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_second      = 1'b0;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                if (i_status.kind == KIND_CLEAR) begin
                    n_state = S_CLR;
                end else if (i_status.kind == KIND_QUERY || i_status.kind == KIND_UNION) begin
                    if (i_status.idx_err) begin
                        o_cmd.set_err = 1'b1;
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_RD;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_status.is_root) begin
                    if (!r_second) begin
                        o_cmd.save_ra = 1'b1;
                        o_cmd.load_b  = 1'b1;
                        n_second      = 1'b1;
                        n_state       = S_RD;
                    end else begin
                        o_cmd.save_rb = 1'b1;
                        if (i_status.kind == KIND_UNION && !i_status.same_root) begin
                            n_state = S_SZA;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end else begin
                    o_cmd.rd_data_sel = 1'b1;
                    n_state           = S_HOP;
                end
            end
            S_HOP: begin
                o_cmd.hop         = 1'b1;
                o_cmd.rd_data_sel = 1'b1;
                n_state           = S_CHK;
            end
            S_SZA: begin
                n_state = S_SZB;
            end
            S_SZB: begin
                o_cmd.latch_sza = 1'b1;
                o_cmd.sz_sel_rb = 1'b1;
                n_state         = S_LINK;
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule
`default_nettype wire

// File: src/ufe_dp.sv
// ufe_dp: parent and set-size memories, walk registers and result registers.
// Depends on ufe_pkg; driven by ufe_ctrl commands.
`default_nettype none
module ufe_dp #(
    parameter int MAX_ELEMENTS = ufe_pkg::DEF_MAX_ELEMENTS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  ufe_pkg::t_cmd                i_cmd,
    input  wire [ufe_pkg::KIND_W-1:0]    i_kind,
    input  wire [ufe_pkg::IDX_W-1:0]     i_first_index,
    input  wire [ufe_pkg::IDX_W-1:0]     i_second_index,
    input  wire [ufe_pkg::CNT_W-1:0]     i_count,
    output ufe_pkg::t_status             o_status,
    output logic [ufe_pkg::IDX_W-1:0]    o_first_root,
    output logic [ufe_pkg::IDX_W-1:0]    o_second_root,
    output logic                         o_were_connected,
    output logic                         o_index_error
);
    import ufe_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);

    logic [IDX_W-1:0]  mem_parent [MAX_ELEMENTS];
    logic [SIZE_W-1:0] mem_size   [MAX_ELEMENTS];

    logic [KIND_W-1:0] r_kind;
    logic [IDX_W-1:0]  r_a;
    logic [IDX_W-1:0]  r_b;
    logic [IDX_W-1:0]  r_node;
    logic [IDX_W-1:0]  r_ra;
    logic [IDX_W-1:0]  r_rb;
    logic              r_conn;
    logic              r_err;
    logic [SIZE_W-1:0] r_sza;
    logic [AW-1:0]     r_clr;
    logic [IDX_W-1:0]  r_pdata;
    logic [SIZE_W-1:0] r_sdata;

    logic              w_idx_err;
    logic              w_clr_last;
    logic              w_less;
    logic [AW-1:0]     w_p_raddr;
    logic [AW-1:0]     w_s_raddr;
    logic              w_p_we;
    logic [AW-1:0]     w_p_waddr;
    logic [IDX_W-1:0]  w_p_wdata;
    logic              w_s_we;
    logic [AW-1:0]     w_s_waddr;
    logic [SIZE_W-1:0] w_s_wdata;

    assign w_idx_err = (32'(r_a) >= 32'(i_count)) || (32'(r_a) >= 32'(MAX_ELEMENTS))
                    || (32'(r_b) >= 32'(i_count)) || (32'(r_b) >= 32'(MAX_ELEMENTS));
    assign w_clr_last = (r_clr == AW'(MAX_ELEMENTS - 1));
    assign w_less     = (r_sza < r_sdata);

    assign o_status.kind      = r_kind;
    assign o_status.idx_err   = w_idx_err;
    assign o_status.is_root   = (r_pdata == r_node);
    assign o_status.same_root = (r_ra == r_node);
    assign o_status.clr_last  = w_clr_last;

    assign w_p_raddr = i_cmd.rd_data_sel ? AW'(r_pdata) : AW'(r_node);
    assign w_s_raddr = i_cmd.sz_sel_rb ? AW'(r_rb) : AW'(r_ra);

    always_comb begin
        w_p_we    = 1'b0;
        w_p_waddr = r_clr;
        w_p_wdata = IDX_W'(r_clr);
        w_s_we    = 1'b0;
        w_s_waddr = r_clr;
        w_s_wdata = SIZE_W'(1);
        if (i_cmd.clr_step) begin
            w_p_we = 1'b1;
            w_s_we = 1'b1;
        end else if (i_cmd.hop) begin
            w_p_we    = 1'b1;
            w_p_waddr = AW'(r_node);
            w_p_wdata = r_pdata;
        end else if (i_cmd.link) begin
            w_p_we    = 1'b1;
            w_s_we    = 1'b1;
            w_s_wdata = r_sza + r_sdata;
            if (w_less) begin
                w_p_waddr = AW'(r_ra);
                w_p_wdata = r_rb;
                w_s_waddr = AW'(r_rb);
            end else begin
                w_p_waddr = AW'(r_rb);
                w_p_wdata = r_ra;
                w_s_waddr = AW'(r_ra);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_we) begin
            mem_parent[w_p_waddr] <= w_p_wdata;
        end
        r_pdata <= mem_parent[w_p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_s_we) begin
            mem_size[w_s_waddr] <= w_s_wdata;
        end
        r_sdata <= mem_size[w_s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= w_clr_last ? '0 : r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_a    <= i_first_index;
            r_b    <= i_second_index;
            r_node <= i_first_index;
            r_ra   <= '0;
            r_rb   <= '0;
            r_conn <= 1'b0;
            r_err  <= 1'b0;
        end else begin
            if (i_cmd.load_b) begin
                r_node <= r_b;
            end
            if (i_cmd.hop) begin
                r_node <= r_pdata;
            end
            if (i_cmd.save_ra) begin
                r_ra <= r_node;
            end
            if (i_cmd.save_rb) begin
                r_rb   <= r_node;
                r_conn <= (r_ra == r_node);
            end
            if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
        end
        if (i_cmd.latch_sza) begin
            r_sza <= r_sdata;
        end
    end

    assign o_first_root     = r_ra;
    assign o_second_root    = r_rb;
    assign o_were_connected = r_conn;
    assign o_index_error    = r_err;

endmodule
`default_nettype wire

// File: src/union_find_engine.sv
// union_find_engine: top level of the disjoint-set engine with its register port.
// Depends on ufe_pkg, ufe_ctrl and ufe_dp.
//
// Usage: raise start with kind, first and second index; the transaction is taken
// at an edge with start high and busy low. Kinds: query, union, clear to
// singletons. Each transaction gives exactly one result, shown for one cycle
// with o_done high; the receiver cannot stall it.
// A query or union finds both roots with path-halving hops in the parent memory;
// a union of two sets then reads both set sizes and links the smaller root under
// the larger; clear rebuilds every entry; an out-of-range index or unused kind goes straight to o_done.
// Each hop is a parent-memory read followed by a read-and-write of the parent
// memory, which has a single read port. One transaction at a time.
// Register element_count sits at byte address 0 of the APB port; write it
// only while busy is low.
// Reset: element_count returns to 1024, then a clearing pass over all
// MAX_ELEMENTS entries rebuilds the singleton tables with busy held high.
`default_nettype none
module union_find_engine #(
    parameter int MAX_ELEMENTS = ufe_pkg::DEF_MAX_ELEMENTS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire [ufe_pkg::KIND_W-1:0]     i_kind,
    input  wire [ufe_pkg::IDX_W-1:0]      i_first_index,
    input  wire [ufe_pkg::IDX_W-1:0]      i_second_index,
    output logic                          o_done,
    output logic [ufe_pkg::IDX_W-1:0]     o_first_root,
    output logic [ufe_pkg::IDX_W-1:0]     o_second_root,
    output logic                          o_were_connected,
    output logic                          o_index_error,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [ufe_pkg::PADDR_W-1:0]    paddr,
    input  wire [ufe_pkg::DATA_W-1:0]     pwdata,
    output logic [ufe_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import ufe_pkg::*;

    logic [CNT_W-1:0] r_count;
    t_cmd             w_cmd;
    t_status          w_status;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ELEMENT_COUNT);
    assign prdata   = (paddr[2] == REG_ELEMENT_COUNT) ? DATA_W'(r_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (w_cfg_wr) begin
            r_count <= pwdata[CNT_W-1:0];
        end
    end

    ufe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    ufe_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_kind           (i_kind),
        .i_first_index    (i_first_index),
        .i_second_index   (i_second_index),
        .i_count          (r_count),
        .o_status         (w_status),
        .o_first_root     (o_first_root),
        .o_second_root    (o_second_root),
        .o_were_connected (o_were_connected),
        .o_index_error    (o_index_error)
    );

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_index_error) |->
            (o_first_root == '0 && o_second_root == '0 && !o_were_connected))
        else $error("index error result carries non-zero fields");

    a_conn_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_were_connected) |-> (o_first_root == o_second_root))
        else $error("connected flag with differing roots");

endmodule
`default_nettype wire
